// ===== sv/nsm_pkg.sv =====
// Shared types and constants for the nearest-site Minkowski labelling engine.
// Used by nsm_cell and nearest_site_minkowski; depends on nothing else.
package nsm_pkg;

    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned PIX_W   = 10;
    localparam int unsigned AD_W    = 12;
    localparam int unsigned SQ_W    = 2 * AD_W;
    localparam int unsigned DIST_W  = 48;

    // Largest possible distance: 2 * 3071^4
    localparam logic [DIST_W-1:0] DIST_MAX = 48'd177889068687362;

    // Minkowski order codes
    typedef logic [2:0] ord_t;
    localparam ord_t ORD_LINEAR  = 3'd1;
    localparam ord_t ORD_SQUARE  = 3'd2;
    localparam ord_t ORD_CUBE    = 3'd3;
    localparam ord_t ORD_QUARTIC = 3'd4;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_EXPONENT   = 1'b0;
    localparam logic REG_SITE_COUNT = 1'b1;

    // Item token that walks down the cell chain
    typedef struct packed {
        logic                      valid;
        logic                      mode;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] site_row;
        logic signed [COORD_W-1:0] site_col;
        logic [PIX_W-1:0]          pixel_row;
        logic [PIX_W-1:0]          pixel_col;
    } tok_t;

    // Running best match that trails the query token
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
        logic [DIST_W-1:0] distance;
    } best_t;

endpackage

// ===== sv/nearest_site_minkowski.sv =====
// Top level of the nearest-site Minkowski labelling engine: APB registers,
// input acceptance and the chain of nsm_cell site cells. Depends on nsm_pkg.
//
//   channel | ports                    | direction | carries
//   --------+--------------------------+-----------+-------------------------------
//   s_      | s_valid / s_ready        | in        | mode, slot, site and pixel
//   m_      | m_valid / m_ready        | out       | nearest_site, best_distance
//   apb     | psel/penable/pwrite/...  | in        | exponent (0x0), site_count (0x4)
//
// One item per cycle enters the chain while it is not stalled; a query result
// passes each cell's three distance stages and best register along the chain.
// Loads travel the chain too, so every query sees exactly the loads before it.
// A result held on m_ stalls the whole chain and drops s_ready in that cycle.
// Reset is synchronous; the site table itself is not cleared.
module nearest_site_minkowski #(
    parameter int unsigned NUM_SITES = 16,
    parameter int unsigned MAX_ORDER = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [nsm_pkg::SLOT_W-1:0]         s_site_slot,
    input  logic signed [nsm_pkg::COORD_W-1:0] s_site_row,
    input  logic signed [nsm_pkg::COORD_W-1:0] s_site_col,
    input  logic [nsm_pkg::PIX_W-1:0]          s_pixel_row,
    input  logic [nsm_pkg::PIX_W-1:0]          s_pixel_col,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [nsm_pkg::SLOT_W-1:0]         m_nearest_site,
    output logic [nsm_pkg::DIST_W-1:0]         m_best_distance
);
    import nsm_pkg::*;

    logic [2:0]  exponent_reg;
    logic [4:0]  site_count_reg;
    logic        cfg_write;
    ord_t        order_eff;
    logic [4:0]  count_eff;
    logic        adv;
    logic [NUM_SITES-1:0] cell_on;
    tok_t        tok_w  [NUM_SITES+1];
    best_t       best_w [NUM_SITES+1];

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg   <= 3'd2;
            site_count_reg <= 5'd16;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_EXPONENT:   exponent_reg   <= pwdata[2:0];
                REG_SITE_COUNT: site_count_reg <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPONENT:   prdata = {29'd0, exponent_reg};
            REG_SITE_COUNT: prdata = {27'd0, site_count_reg};
        endcase
    end

    // Clamp order and site count to their usable ranges
    always_comb begin
        if (exponent_reg == 3'd0)
            order_eff = ORD_LINEAR;
        else if (32'(exponent_reg) > MAX_ORDER)
            order_eff = ord_t'(MAX_ORDER);
        else
            order_eff = exponent_reg;

        if (site_count_reg == 5'd0)
            count_eff = 5'd1;
        else if (32'(site_count_reg) > NUM_SITES)
            count_eff = 5'(NUM_SITES);
        else
            count_eff = site_count_reg;
    end

    // Advance the whole chain unless a finished result is waiting and not taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Feed the accepted item into the head of the chain
    always_comb begin
        tok_w[0].valid     = s_valid;
        tok_w[0].mode      = s_mode;
        tok_w[0].slot      = s_site_slot;
        tok_w[0].site_row  = s_site_row;
        tok_w[0].site_col  = s_site_col;
        tok_w[0].pixel_row = s_pixel_row;
        tok_w[0].pixel_col = s_pixel_col;
    end

    assign best_w[0] = '0;

    for (genvar g = 0; g < NUM_SITES; g++) begin : g_cell
        assign cell_on[g] = ({27'd0, count_eff} > 32'(g));

        nsm_cell #(
            .INDEX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .order    (order_eff),
            .active   (cell_on[g]),
            .tok_in   (tok_w[g]),
            .best_in  (best_w[g]),
            .tok_out  (tok_w[g+1]),
            .best_out (best_w[g+1])
        );
    end

    // Last cell's best register is the output register
    assign m_valid         = best_w[NUM_SITES].valid;
    assign m_nearest_site  = best_w[NUM_SITES].idx;
    assign m_best_distance = best_w[NUM_SITES].distance;

    // A blocked result must hold off new transfers
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while a result is blocked");

    // Distance never exceeds the largest exact sum
    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_best_distance <= DIST_MAX))
        else $error("distance out of range");

    // Reported site lies within the searched range
    a_site_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({27'd0, count_eff} > {28'd0, m_nearest_site}))
        else $error("nearest site outside searched range");

endmodule

// ===== sv/nsm_cell.sv =====
// One site cell of the nearest-site chain: holds one site, computes the
// distance to each passing query over three stages and updates the best match.
// Depends on nsm_pkg.
module nsm_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  nsm_pkg::ord_t order,
    input  logic          active,
    input  nsm_pkg::tok_t tok_in,
    input  nsm_pkg::best_t best_in,
    output nsm_pkg::tok_t tok_out,
    output nsm_pkg::best_t best_out
);
    import nsm_pkg::*;

    localparam bit FIRST = (INDEX == 0);

    // Absolute difference of an unsigned pixel and a signed site coordinate
    function automatic logic [AD_W-1:0] abs_diff(input logic [PIX_W-1:0] pix,
                                                  input logic signed [COORD_W-1:0] site);
        logic signed [COORD_W:0] diff;
        diff = $signed({{(COORD_W + 1 - PIX_W){1'b0}}, pix}) - $signed({site[COORD_W-1], site});
        return diff[COORD_W] ? AD_W'(-diff) : diff[AD_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] power_sel(input logic [AD_W-1:0] ad,
                                                     input logic [SQ_W-1:0] sq,
                                                     input ord_t ord);
        logic [DIST_W-1:0] ad_w, sq_w;
        ad_w = {{(DIST_W - AD_W){1'b0}}, ad};
        sq_w = {{(DIST_W - SQ_W){1'b0}}, sq};
        unique case (ord)
            ORD_LINEAR:  return ad_w;
            ORD_SQUARE:  return sq_w;
            ORD_CUBE:    return sq_w * ad_w;
            ORD_QUARTIC: return sq_w * sq_w;
            default:     return ad_w;
        endcase
    endfunction

    logic signed [COORD_W-1:0] site_row_reg, site_col_reg;
    tok_t                      tok_reg;
    logic                      s1_q_reg, s2_q_reg, s3_q_reg;
    logic [AD_W-1:0]           s1_ady_reg, s1_adx_reg, s2_ady_reg, s2_adx_reg;
    logic [SQ_W-1:0]           s2_sqy_reg, s2_sqx_reg;
    logic [DIST_W-1:0]         s3_pwy_reg, s3_pwx_reg;
    best_t                     best_reg, best_next;
    logic [DIST_W-1:0]         dist_sum;
    logic                      take;
    logic                      load_hit;

    assign load_hit = tok_in.valid && (tok_in.mode == MODE_LOAD)
                      && ({{(32 - SLOT_W){1'b0}}, tok_in.slot} == 32'(INDEX));

    // Site storage: written when a load for this slot passes
    always_ff @(posedge aclk) begin
        if (adv && load_hit) begin
            site_row_reg <= tok_in.site_row;
            site_col_reg <= tok_in.site_col;
        end
    end

    // Token hop and distance stages; only the flags are cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid  <= 1'b0;
            s1_q_reg       <= 1'b0;
            s2_q_reg       <= 1'b0;
            s3_q_reg       <= 1'b0;
            best_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg  <= tok_in;
            s1_q_reg <= tok_in.valid && (tok_in.mode == MODE_QUERY);
            s2_q_reg <= s1_q_reg;
            s3_q_reg <= s2_q_reg;
            // stage 1: absolute differences
            s1_ady_reg <= abs_diff(tok_in.pixel_row, site_row_reg);
            s1_adx_reg <= abs_diff(tok_in.pixel_col, site_col_reg);
            // stage 2: squares
            s2_ady_reg <= s1_ady_reg;
            s2_adx_reg <= s1_adx_reg;
            s2_sqy_reg <= {{AD_W{1'b0}}, s1_ady_reg} * {{AD_W{1'b0}}, s1_ady_reg};
            s2_sqx_reg <= {{AD_W{1'b0}}, s1_adx_reg} * {{AD_W{1'b0}}, s1_adx_reg};
            // stage 3: power of the selected order
            s3_pwy_reg <= power_sel(s2_ady_reg, s2_sqy_reg, order);
            s3_pwx_reg <= power_sel(s2_adx_reg, s2_sqx_reg, order);
            best_reg   <= best_next;
        end
    end

    // Stage 4: sum and compare against the best so far; lower index keeps ties
    always_comb begin
        dist_sum        = s3_pwy_reg + s3_pwx_reg;
        take            = active && (FIRST || (dist_sum < best_in.distance));
        best_next.valid = s3_q_reg;
        if (take) begin
            best_next.idx      = SLOT_W'(INDEX);
            best_next.distance = dist_sum;
        end else begin
            best_next.idx      = best_in.idx;
            best_next.distance = best_in.distance;
        end
    end

    assign tok_out  = tok_reg;
    assign best_out = best_reg;

endmodule

// ===== sim/nearest_site_minkowski_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_site_minkowski: drives loads, queries and
// register writes, and checks labels and distances against its own site predictor. Needs nsm_pkg.
module nearest_site_minkowski_tb;
    import nsm_pkg::*;

    localparam int SITE_SLOTS   = 16;
    localparam int CHAIN_CYCLES = SITE_SLOTS + 2;
    localparam int DRAIN_CYCLES = CHAIN_CYCLES + 12;
    localparam int HOLD_CYCLES  = 120;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 54;

    // Site table copy, register copy and the queue of pending labels
    class site_label_board;
        logic signed [COORD_W-1:0] site_y [SITE_SLOTS];
        logic signed [COORD_W-1:0] site_x [SITE_SLOTS];
        logic [2:0]                order;
        logic [4:0]                span;
        logic [SLOT_W-1:0]         label_q [$];
        logic [DIST_W-1:0]         dist_q [$];
        int                        errors;

        function new();
            for (int i = 0; i < SITE_SLOTS; i++) begin
                site_y[i] = '0;
                site_x[i] = '0;
            end
            order  = ORD_SQUARE;
            span   = 5'd16;
            errors = 0;
        endfunction

        function void set_register(logic which, logic [31:0] value);
            if (which == REG_EXPONENT)
                order = value[2:0];
            else
                span = value[4:0];
        endfunction

        function longint unsigned raise(longint unsigned base, int p);
            longint unsigned r;
            r = 1;
            for (int i = 0; i < p; i++)
                r = r * base;
            return r;
        endfunction

        // Update the table on a load, predict the nearest site on a query
        function void note_item(logic mode, logic [SLOT_W-1:0] slot,
                                logic signed [COORD_W-1:0] row,
                                logic signed [COORD_W-1:0] col,
                                logic [PIX_W-1:0] prow, logic [PIX_W-1:0] pcol);
            int              p, n, py, px, sy, sx, dy, dx;
            longint unsigned d, best;
            int              best_idx;
            if (mode == MODE_LOAD) begin
                site_y[slot] = row;
                site_x[slot] = col;
                return;
            end
            p = order;
            if (p < ORD_LINEAR) p = ORD_LINEAR;
            if (p > ORD_QUARTIC) p = ORD_QUARTIC;
            n = span;
            if (n < 1) n = 1;
            if (n > SITE_SLOTS) n = SITE_SLOTS;
            py = prow;
            px = pcol;
            best = 0;
            best_idx = 0;
            for (int i = 0; i < n; i++) begin
                sy = site_y[i];
                sx = site_x[i];
                dy = py - sy;
                dx = px - sx;
                if (dy < 0) dy = -dy;
                if (dx < 0) dx = -dx;
                d = raise(dy, p) + raise(dx, p);
                // strict compare keeps the lower index on a tie
                if (i == 0 || d < best) begin
                    best = d;
                    best_idx = i;
                end
            end
            label_q.push_back(best_idx[SLOT_W-1:0]);
            dist_q.push_back(best[DIST_W-1:0]);
        endfunction

        function void check_label(logic [SLOT_W-1:0] site, logic [DIST_W-1:0] distance);
            logic [SLOT_W-1:0] want_site;
            logic [DIST_W-1:0] want_dist;
            if (label_q.size() == 0) begin
                $display("%0t: result with nothing pending: site %0d dist %0d",
                         $time, site, distance);
                errors++;
                return;
            end
            want_site = label_q.pop_front();
            want_dist = dist_q.pop_front();
            if (site !== want_site) begin
                $display("%0t: nearest_site expected %0d actual %0d",
                         $time, want_site, site);
                errors++;
            end
            if (distance !== want_dist) begin
                $display("%0t: best_distance expected %0d actual %0d",
                         $time, want_dist, distance);
                errors++;
            end
        endfunction

        function int pending();
            return label_q.size();
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        psel, penable, pwrite, pready;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata, prdata;
    logic                        s_valid, s_ready, s_mode;
    logic [SLOT_W-1:0]           s_site_slot;
    logic signed [COORD_W-1:0]   s_site_row, s_site_col;
    logic [PIX_W-1:0]            s_pixel_row, s_pixel_col;
    logic                        m_valid, m_ready;
    logic [SLOT_W-1:0]           m_nearest_site;
    logic [DIST_W-1:0]           m_best_distance;

    site_label_board board = new();
    int  cycle_count = 0;
    bit  hold_request = 1'b0;
    bit  steady = 1'b0;

    nearest_site_minkowski dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_site_slot     (s_site_slot),
        .s_site_row      (s_site_row),
        .s_site_col      (s_site_col),
        .s_pixel_row     (s_pixel_row),
        .s_pixel_col     (s_pixel_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_site  (m_nearest_site),
        .m_best_distance (m_best_distance)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_item(s_mode, s_site_slot, s_site_row, s_site_col,
                            s_pixel_row, s_pixel_col);
        if (aresetn && m_valid && m_ready)
            board.check_label(m_nearest_site, m_best_distance);
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Result receiver: random stalls, steady stretches, one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 17);
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(logic mode, logic [SLOT_W-1:0] slot,
                             logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                             logic [PIX_W-1:0] prow, logic [PIX_W-1:0] pcol);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_site_slot <= slot;
        s_site_row  <= row;
        s_site_col  <= col;
        s_pixel_row <= prow;
        s_pixel_col <= pcol;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_site(logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] row,
                             logic [COORD_W-1:0] col);
        send_item(MODE_LOAD, slot, row, col, PIX_W'($urandom_range(1023)),
                  PIX_W'($urandom_range(1023)));
    endtask

    task automatic query_pixel(logic [PIX_W-1:0] prow, logic [PIX_W-1:0] pcol);
        send_item(MODE_QUERY, SLOT_W'($urandom_range(15)), COORD_W'($urandom_range(4095)),
                  COORD_W'($urandom_range(4095)), prow, pcol);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Drop valid, wait for every label, then let loads clear the chain
    task automatic wait_quiet();
        idle_sender(1);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(logic which, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.set_register(which, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly queries with random loads; some loads duplicate a site to force ties
    task automatic random_items(int count, bit with_hold);
        int                 pick, src;
        logic [COORD_W-1:0] row, col;
        for (int k = 0; k < count; k++) begin
            if (!steady && $urandom_range(99) < 17)
                idle_sender(1);
            if (with_hold && k == 20)
                hold_request = 1'b1;
            if ($urandom_range(99) < 22) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    row = COORD_W'($urandom_range(4095));
                    col = COORD_W'($urandom_range(4095));
                end else if (pick < 85) begin
                    row = COORD_W'($urandom_range(1023));
                    col = COORD_W'($urandom_range(1023));
                end else begin
                    src = $urandom_range(SITE_SLOTS - 1);
                    row = board.site_y[src];
                    col = board.site_x[src];
                end
                load_site(SLOT_W'($urandom_range(15)), row, col);
            end else begin
                query_pixel(PIX_W'($urandom_range(1023)), PIX_W'($urandom_range(1023)));
            end
        end
    endtask

    logic [2:0] phase_order [PHASES] = '{ORD_LINEAR, ORD_QUARTIC, ORD_CUBE, 3'd0,
                                         3'd7, 3'd5, ORD_SQUARE, 3'd6};
    logic [4:0] phase_span  [PHASES] = '{5'd16, 5'd1, 5'd7, 5'd0,
                                         5'd31, 5'd17, 5'd12, 5'd20};

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_mode      = MODE_LOAD;
        s_site_slot = '0;
        s_site_row  = '0;
        s_site_col  = '0;
        s_pixel_row = '0;
        s_pixel_col = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: fill the whole table under the reset settings, then query
        for (int i = 0; i < SITE_SLOTS; i++) begin
            case (i)
                0:       load_site(SLOT_W'(i), 12'sh800, 12'sh800);
                5, 6:    load_site(SLOT_W'(i), 12'sd0, 12'sd0);
                9:       load_site(SLOT_W'(i), 12'sd1023, 12'sd1023);
                10:      load_site(SLOT_W'(i), 12'shFFF, 12'shFFF);
                15:      load_site(SLOT_W'(i), 12'sh7FF, 12'sh7FF);
                default: load_site(SLOT_W'(i), COORD_W'($urandom_range(1023)),
                                   COORD_W'($urandom_range(1023)));
            endcase
        end
        query_pixel(10'd0, 10'd0);
        query_pixel(10'd1023, 10'd1023);
        query_pixel(10'd0, 10'd1023);
        query_pixel(10'd1023, 10'd0);
        query_pixel(10'd512, 10'd512);
        wait_quiet();

        // Phases: each register setting, extremes and out-of-range values included
        for (int ph = 0; ph < PHASES; ph++) begin
            write_register(REG_EXPONENT, {29'd0, phase_order[ph]});
            write_register(REG_SITE_COUNT, {27'd0, phase_span[ph]});
            steady = (ph == 4);
            if (phase_order[ph] == ORD_QUARTIC && phase_span[ph] == 5'd1) begin
                // largest distance: farthest corner under the quartic order
                load_site(4'd0, 12'sh800, 12'sh800);
                query_pixel(10'd1023, 10'd1023);
            end
            random_items(PHASE_ITEMS, ph == 2);
            wait_quiet();
            steady = 1'b0;
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
